// ----- design/rcw_pkg.sv -----
`default_nettype none

package rcw_pkg;

  localparam int unsigned LETTERS    = 26;
  localparam int unsigned NUM_ROTORS = 3;

  typedef logic [4:0] letter_t;
  typedef logic [1:0] rotor_idx_t;

  localparam letter_t    LAST_LETTER   = 5'd25;
  localparam letter_t    LETTER_COUNT  = 5'd26;
  localparam letter_t    REFLECT_SHIFT = 5'd13;

  localparam rotor_idx_t ROTOR_FAST   = 2'd0;
  localparam rotor_idx_t ROTOR_MIDDLE = 2'd1;
  localparam rotor_idx_t ROTOR_SLOW   = 2'd2;

  localparam logic KIND_LETTER  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    letter_t fast;
    letter_t middle;
    letter_t slow;
  } positions_t;

  // entry i is the wired contact for input contact i (A = 0)
  localparam letter_t FWD_WIRING [NUM_ROTORS][LETTERS] = '{
    '{5'd16, 5'd22, 5'd4,  5'd17, 5'd19, 5'd24, 5'd20, 5'd8,  5'd14, 5'd15,
      5'd0,  5'd18, 5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10, 5'd11, 5'd25,
      5'd23, 5'd2,  5'd21, 5'd1,  5'd13, 5'd12},
    '{5'd12, 5'd11, 5'd15, 5'd14, 5'd10, 5'd8,  5'd9,  5'd13, 5'd1,  5'd7,
      5'd20, 5'd24, 5'd6,  5'd21, 5'd2,  5'd5,  5'd19, 5'd17, 5'd3,  5'd23,
      5'd18, 5'd4,  5'd22, 5'd16, 5'd0,  5'd25},
    '{5'd11, 5'd10, 5'd9,  5'd7,  5'd6,  5'd5,  5'd3,  5'd18, 5'd0,  5'd12,
      5'd15, 5'd14, 5'd8,  5'd20, 5'd13, 5'd1,  5'd24, 5'd19, 5'd21, 5'd2,
      5'd17, 5'd4,  5'd23, 5'd25, 5'd22, 5'd16}
  };

  localparam letter_t INV_WIRING [NUM_ROTORS][LETTERS] = '{
    '{5'd10, 5'd23, 5'd21, 5'd12, 5'd2,  5'd13, 5'd14, 5'd15, 5'd7,  5'd16,
      5'd17, 5'd18, 5'd25, 5'd24, 5'd8,  5'd9,  5'd0,  5'd3,  5'd11, 5'd4,
      5'd6,  5'd22, 5'd1,  5'd20, 5'd5,  5'd19},
    '{5'd24, 5'd8,  5'd14, 5'd18, 5'd21, 5'd15, 5'd12, 5'd9,  5'd5,  5'd6,
      5'd4,  5'd1,  5'd0,  5'd7,  5'd3,  5'd2,  5'd23, 5'd17, 5'd20, 5'd16,
      5'd10, 5'd13, 5'd22, 5'd19, 5'd11, 5'd25},
    '{5'd8,  5'd15, 5'd19, 5'd6,  5'd21, 5'd5,  5'd4,  5'd3,  5'd12, 5'd2,
      5'd1,  5'd0,  5'd9,  5'd14, 5'd11, 5'd10, 5'd25, 5'd20, 5'd7,  5'd17,
      5'd13, 5'd18, 5'd24, 5'd22, 5'd16, 5'd23}
  };

  function automatic letter_t sub_mod(input letter_t x, input letter_t p);
    logic [5:0] wrapped;
    wrapped = {1'b0, x} + {1'b0, LETTER_COUNT} - {1'b0, p};
    return (x >= p) ? (x - p) : wrapped[4:0];
  endfunction

  function automatic letter_t add_mod(input letter_t a, input letter_t p);
    logic [5:0] sum;
    logic [5:0] reduced;
    sum     = {1'b0, a} + {1'b0, p};
    reduced = sum - {1'b0, LETTER_COUNT};
    return (sum >= {1'b0, LETTER_COUNT}) ? reduced[4:0] : sum[4:0];
  endfunction

  function automatic letter_t reduce_letter(input letter_t x);
    return (x >= LETTER_COUNT) ? (x - LETTER_COUNT) : x;
  endfunction

  function automatic letter_t rotor_in(input rotor_idx_t r, input letter_t x,
                                       input letter_t pos);
    return FWD_WIRING[r][sub_mod(x, pos)];
  endfunction

  function automatic letter_t rotor_out(input rotor_idx_t r, input letter_t y,
                                        input letter_t pos);
    return add_mod(INV_WIRING[r][y], pos);
  endfunction

endpackage

`default_nettype wire

// ----- design/rcw_positions.sv -----
`default_nettype none

module rcw_positions
  import rcw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       restart,
  output positions_t      pos
);

  positions_t pos_next;

  always_comb begin
    pos_next = pos;
    if (restart) begin
      pos_next = '0;
    end else if (step) begin
      if (pos.fast == LAST_LETTER) begin
        pos_next.fast = '0;
        if (pos.middle == LAST_LETTER) begin
          pos_next.middle = '0;
          pos_next.slow   = (pos.slow == LAST_LETTER) ? '0 : pos.slow + 5'd1;
        end else begin
          pos_next.middle = pos.middle + 5'd1;
        end
      end else begin
        pos_next.fast = pos.fast + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/rcw_scrambler.sv -----
`default_nettype none

module rcw_scrambler
  import rcw_pkg::*;
(
  input  wire letter_t    letter,
  input  wire positions_t pos,
  output letter_t         cipher
);

  letter_t x0, f1, f2, f3, refl, b3, b2;

  always_comb begin
    x0     = reduce_letter(letter);
    f1     = rotor_in(ROTOR_FAST,   x0, pos.fast);
    f2     = rotor_in(ROTOR_MIDDLE, f1, pos.middle);
    f3     = rotor_in(ROTOR_SLOW,   f2, pos.slow);
    refl   = add_mod(f3, REFLECT_SHIFT);
    b3     = rotor_out(ROTOR_SLOW,   refl, pos.slow);
    b2     = rotor_out(ROTOR_MIDDLE, b3,   pos.middle);
    cipher = rotor_out(ROTOR_FAST,   b2,   pos.fast);
  end

endmodule

`default_nettype wire

// ----- design/rotor_cipher_three_wheel_unit.sv -----
// Three-rotor letter cipher.
// Input channel (in_valid/in_ready): one beat carries kind and letter.
//   kind = 0 enciphers letter (values 26..31 are taken mod 26) and steps the
//   rotors like an odometer; kind = 1 zeroes all rotor positions and gives
//   no result beat.
// Output channel (out_valid/out_ready): one cipher_letter beat per
//   enciphered letter, in input order.
// Path: a letter is taken into the input register at its accepting edge,
//   goes through the rotor lookups, and lands in the result register once
//   that register is empty or being read out; out_valid is high after that.
// Throughput: one beat per cycle while out_ready is high; the only path is six
//   table lookups with mod-26 adds between the input and result registers.
// Rotor positions advance at the input beat, so each letter is enciphered
//   with the positions it met on arrival.
// Stall: while out_ready is low the result holds; one more letter waits in
//   the input register, then in_ready drops.
// Reset (rst, synchronous): both stages empty, positions zero.
`default_nettype none

module rotor_cipher_three_wheel_unit
  import rcw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    kind,
  input  wire letter_t letter,
  output logic         out_valid,
  input  wire logic    out_ready,
  output letter_t      cipher_letter
);

  positions_t pos;
  logic       in_fire;
  logic       take_letter;
  logic       s1_advance;

  logic       s1_valid;
  letter_t    s1_letter;
  positions_t s1_pos;
  letter_t    cipher;

  assign s1_advance  = !out_valid || out_ready;
  assign in_ready    = !s1_valid || s1_advance;
  assign in_fire     = in_valid && in_ready;
  assign take_letter = in_fire && (kind == KIND_LETTER);

  rcw_positions u_positions (
    .clk     (clk),
    .rst     (rst),
    .step    (take_letter),
    .restart (in_fire && (kind == KIND_RESTART)),
    .pos     (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= take_letter;
    end
  end

  always_ff @(posedge clk) begin
    if (take_letter) begin
      s1_letter <= letter;
      s1_pos    <= pos;
    end
  end

  rcw_scrambler u_scrambler (
    .letter (s1_letter),
    .pos    (s1_pos),
    .cipher (cipher)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      cipher_letter <= cipher;
    end
  end

endmodule

`default_nettype wire

// ----- design/rcw_checker.sv -----
`default_nettype none

module rcw_checker
  import rcw_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire logic    kind,
  input wire letter_t letter,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire letter_t cipher_letter
);

  logic letter_beat;
  assign letter_beat = in_valid && in_ready && (kind == KIND_LETTER);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_letter))
    else $error("result beat changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cipher_letter < LETTER_COUNT)
    else $error("cipher letter out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(letter_beat, 2))
    else $error("result beat without a letter beat two cycles earlier");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !$isunknown({kind, letter}))
    else $error("input beat fields unknown");

endmodule

bind rotor_cipher_three_wheel_unit rcw_checker u_rcw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .kind          (kind),
  .letter        (letter),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .cipher_letter (cipher_letter)
);

`default_nettype wire
